// ----- rtl/npcm_pkg.sv -----
// Shared types, constants and helpers for the nearest palette color mapper.
package npcm_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int INDEX_LIMIT         = 256;
   localparam int CHAN_W              = 8;
   localparam int IDX_W               = 8;
   localparam int DIST_W              = 10;
   localparam int COUNT_W             = 9;
   localparam int MODE_W              = 2;
   localparam int WORD_W              = 3 * CHAN_W;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_ADDR_W          = 3;

   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MATCH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic start;
      logic step;
   } srch_ctrl_type;

   function automatic logic [DIST_W-1:0] chan_dist(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return DIST_W'(d);
   endfunction

endpackage

// ----- rtl/nearest_palette_color_mapper_top.sv -----
// Top level of the nearest palette color mapper: cell ring, compare unit, handshakes.
//
// Input channel req_*: one transaction per command, accepted when req_valid is high
// and req_stall low. Mode 0 writes a palette entry and gives no result.
// Mode 1 searches the first palette_count entries for the smallest L1 distance
// (lowest index wins a tie); mode 2 returns the color of one entry.
// The palette sits in a ring of PALETTE_ENTRIES cells that rotates one place per
// cycle during a scan past a single compare unit. After acceptance, modes 1 and 2
// pass through the scan and done states and load the result register; the next
// item is taken only once the block is back in idle.
// Result channel rsp_*: a result register holds one transaction; a new item is
// accepted while it waits. If the receiver stalls, a finished scan is held until
// the register frees.
// Mode 3 is dropped without a result.
// csr_*: palette_count at byte address 0; the user must write it only while the block is idle (not enforced).
// Reset (synchronous, active high) sets palette_count to 256 and empties the result
// register; palette entries are undefined until written.
module nearest_palette_color_mapper_top #(
   parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [npcm_pkg::MODE_W-1:0]       req_mode,
   input  logic [npcm_pkg::IDX_W-1:0]        req_entry,
   input  logic [npcm_pkg::CHAN_W-1:0]       req_red,
   input  logic [npcm_pkg::CHAN_W-1:0]       req_green,
   input  logic [npcm_pkg::CHAN_W-1:0]       req_blue,
   input  logic                              req_last_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [npcm_pkg::IDX_W-1:0]        rsp_palette_index,
   output logic [npcm_pkg::CHAN_W-1:0]       rsp_out_red,
   output logic [npcm_pkg::CHAN_W-1:0]       rsp_out_green,
   output logic [npcm_pkg::CHAN_W-1:0]       rsp_out_blue,
   output logic [npcm_pkg::DIST_W-1:0]       rsp_distance,
   output logic                              rsp_last_out,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [npcm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [npcm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [npcm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import npcm_pkg::*;

   localparam int CW    = $clog2(PALETTE_ENTRIES + 1);
   localparam int CNT_W = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PALETTE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] LIM =
      CNT_W'((PALETTE_ENTRIES > INDEX_LIMIT) ? INDEX_LIMIT : PALETTE_ENTRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rv_ff, rv_in;
   logic [IDX_W-1:0]   ridx_ff;
   word_type           rword_ff;
   logic [DIST_W-1:0]  rdist_ff;
   logic               rlast_ff;

   logic               accept, wr_en, shift, load, cfg_wr, start;
   logic [CNT_W-1:0]   n_raw, limit;
   srch_ctrl_type      ctrl;
   word_type           ring [PALETTE_ENTRIES];
   logic [IDX_W-1:0]   best_idx;
   word_type           best_word;
   logic [DIST_W-1:0]  best_dist;
   logic               best_last;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign wr_en  = accept && req_mode == MODE_WRITE;
   assign shift  = (state_ff == ST_SCAN);
   assign load   = (state_ff == ST_DONE) && (!rv_ff || !rsp_stall);
   assign start  = accept && (req_mode == MODE_MATCH || req_mode == MODE_LOOKUP);
   assign ctrl   = '{start: start, step: shift};
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2];

   always_comb begin
      n_raw = (count_ff == '0) ? CNT_W'(1) : CNT_W'(count_ff);
      limit = (n_raw > LIM) ? LIM : n_raw;
   end

   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      npcm_cell u_cell (
         .clock    (clock),
         .wr_en    (wr_en && CNT_W'(req_entry) == CNT_W'(i)),
         .wr_data  ({req_red, req_green, req_blue}),
         .shift    (shift),
         .shift_in (ring[(i + 1) % PALETTE_ENTRIES]),
         .q        (ring[i])
      );
   end

   npcm_search #(.CNT_W(CNT_W)) u_search (
      .clock      (clock),
      .ctrl       (ctrl),
      .mode       (req_mode),
      .entry      (req_entry),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .last_pixel (req_last_pixel),
      .cnt        (cnt_ff),
      .limit      (limit),
      .head       (ring[0]),
      .best_idx   (best_idx),
      .best_word  (best_word),
      .best_dist  (best_dist),
      .best_last  (best_last)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rv_in = load ? 1'b1 : (rv_ff && rsp_stall);
      count_in = cfg_wr ? csr_pwdata[COUNT_W-1:0] : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
         count_ff <= COUNT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ridx_ff  <= best_idx;
         rword_ff <= best_word;
         rdist_ff <= best_dist;
         rlast_ff <= best_last;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_palette_index = ridx_ff;
   assign rsp_out_red       = rword_ff[WORD_W-1 -: CHAN_W];
   assign rsp_out_green     = rword_ff[2*CHAN_W-1 -: CHAN_W];
   assign rsp_out_blue      = rword_ff[CHAN_W-1:0];
   assign rsp_distance      = rdist_ff;
   assign rsp_last_out      = rlast_ff;
   assign csr_prdata        = CSR_DATA_W'(count_ff);
   assign csr_pready        = 1'b1;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= LAST_STEP)
      else $error("scan counter out of range");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      load |=> rv_ff && state_ff == ST_IDLE)
      else $error("finished scan not delivered");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rdist_ff <= DIST_W'(765))
      else $error("distance out of range");

endmodule

// ----- rtl/npcm_cell.sv -----
// One palette cell of the rotating entry ring.
module npcm_cell (
   input  logic             clock,
   input  logic             wr_en,
   input  npcm_pkg::word_type wr_data,
   input  logic             shift,
   input  npcm_pkg::word_type shift_in,
   output npcm_pkg::word_type q
);
   import npcm_pkg::*;

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (wr_en) begin
         word_in = wr_data;
      end else if (shift) begin
         word_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;
endmodule

// ----- rtl/npcm_search.sv -----
// Shared distance compare unit fed from the head of the cell ring.
module npcm_search #(
   parameter int CNT_W = 9
) (
   input  logic                             clock,
   input  npcm_pkg::srch_ctrl_type          ctrl,
   input  logic [npcm_pkg::MODE_W-1:0]      mode,
   input  logic [npcm_pkg::IDX_W-1:0]       entry,
   input  logic [npcm_pkg::CHAN_W-1:0]      red,
   input  logic [npcm_pkg::CHAN_W-1:0]      green,
   input  logic [npcm_pkg::CHAN_W-1:0]      blue,
   input  logic                             last_pixel,
   input  logic [CNT_W-1:0]                 cnt,
   input  logic [CNT_W-1:0]                 limit,
   input  npcm_pkg::word_type               head,
   output logic [npcm_pkg::IDX_W-1:0]       best_idx,
   output npcm_pkg::word_type               best_word,
   output logic [npcm_pkg::DIST_W-1:0]      best_dist,
   output logic                             best_last
);
   import npcm_pkg::*;

   logic [MODE_W-1:0] mode_ff,  mode_in;
   logic [IDX_W-1:0]  ent_ff,   ent_in;
   logic [CHAN_W-1:0] r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic              last_ff,  last_in;
   logic [IDX_W-1:0]  bidx_ff,  bidx_in;
   word_type          bword_ff, bword_in;
   logic [DIST_W-1:0] bdist_ff, bdist_in;
   logic [DIST_W-1:0] d;

   always_comb begin
      d = chan_dist(r_ff, head[WORD_W-1 -: CHAN_W])
        + chan_dist(g_ff, head[2*CHAN_W-1 -: CHAN_W])
        + chan_dist(b_ff, head[CHAN_W-1:0]);
      mode_in  = mode_ff;
      ent_in   = ent_ff;
      r_in     = r_ff;
      g_in     = g_ff;
      b_in     = b_ff;
      last_in  = last_ff;
      bidx_in  = bidx_ff;
      bword_in = bword_ff;
      bdist_in = bdist_ff;
      if (ctrl.start) begin
         mode_in  = mode;
         ent_in   = entry;
         r_in     = red;
         g_in     = green;
         b_in     = blue;
         last_in  = last_pixel;
         bidx_in  = (mode == MODE_LOOKUP) ? entry : '0;
         bword_in = '0;
         bdist_in = '0;
      end else if (ctrl.step) begin
         if (mode_ff == MODE_MATCH && cnt < limit &&
             (cnt == '0 || d < bdist_ff)) begin
            bidx_in  = cnt[IDX_W-1:0];
            bword_in = head;
            bdist_in = d;
         end
         if (mode_ff == MODE_LOOKUP && cnt == CNT_W'(ent_ff)) begin
            bword_in = head;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      ent_ff   <= ent_in;
      r_ff     <= r_in;
      g_ff     <= g_in;
      b_ff     <= b_in;
      last_ff  <= last_in;
      bidx_ff  <= bidx_in;
      bword_ff <= bword_in;
      bdist_ff <= bdist_in;
   end

   assign best_idx  = bidx_ff;
   assign best_word = bword_ff;
   assign best_dist = bdist_ff;
   assign best_last = last_ff;
endmodule
